// ----- hdl/cpurc_pkg.sv -----
// Shared constants, codes and the table entry type for the processor registry.
package cpurc_pkg;

   localparam int MAX_CPUS = 64;
   localparam int IDX_W    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
   localparam int CNT_W    = $clog2(MAX_CPUS + 1);

   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_COMMIT = 3'd2;
   localparam logic [2:0] OP_SET    = 3'd3;
   localparam logic [2:0] OP_TICKS  = 3'd4;
   localparam logic [2:0] OP_IRQS   = 3'd5;
   localparam logic [2:0] OP_LOOKUP = 3'd6;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_READY = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_DUPLICATE = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_OFFLINE   = 3'd5;
   localparam logic [2:0] ST_INVALID   = 3'd6;

   typedef struct packed {
      logic [31:0] key;
      logic        online;
      logic [63:0] ticks;
      logic [63:0] irqs;
   } entry_type;

endpackage

// ----- hdl/cpurc_store.sv -----
// Entry memory of the processor registry: one write port, one registered read port.
module cpurc_store (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [cpurc_pkg::IDX_W-1:0]    wr_addr,
   input  cpurc_pkg::entry_type           wr_data,
   input  logic                           rd_en,
   input  logic [cpurc_pkg::IDX_W-1:0]    rd_addr,
   output cpurc_pkg::entry_type           rd_data
);

   cpurc_pkg::entry_type mem [cpurc_pkg::MAX_CPUS];
   cpurc_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/cpu_registry_counter_table.sv -----
// Top level of the processor registry: key scan sequencer, table state and result register.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_valid / req_ready | operation, apic_id, online_flag, amount
//   rsp     | out | rsp_valid / rsp_ready | status, found, logical_index, entry_online,
//           |     |                       | tick_count, interrupt_count, generation_out,
//           |     |                       | online_total
//
// A word's result waits on the key scan, which stops at the first matching key or after
// the last entry; clear skips the scan. The scan makes one compare per cycle through the
// single read port of the entry memory.
// Reset is synchronous and empties the table. A new word is taken while a result waits;
// it stalls before its update cycle until the waiting result is taken.
module cpu_registry_counter_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_apic_id,
   input  logic        req_online_flag,
   input  logic [63:0] req_amount,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_found,
   output logic [5:0]  rsp_logical_index,
   output logic        rsp_entry_online,
   output logic [63:0] rsp_tick_count,
   output logic [63:0] rsp_interrupt_count,
   output logic [63:0] rsp_generation_out,
   output logic [6:0]  rsp_online_total
);

   localparam int IDX_W = cpurc_pkg::IDX_W;
   localparam int CNT_W = cpurc_pkg::CNT_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic [31:0]      id_ff, id_in;
   logic             flag_ff, flag_in;
   logic [63:0]      amount_ff, amount_in;

   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] slot_ff, slot_in;

   logic [CNT_W-1:0] entry_total_ff, entry_total_in;
   logic [CNT_W-1:0] online_ff, online_in;
   logic [63:0]      gen_ff, gen_in;
   logic             ready_ff, ready_in;
   logic             failed_ff, failed_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic             rsp_online_ff, rsp_online_in;
   logic [63:0]      rsp_ticks_ff, rsp_ticks_in;
   logic [63:0]      rsp_irqs_ff, rsp_irqs_in;
   logic [63:0]      rsp_gen_ff, rsp_gen_in;
   logic [CNT_W-1:0] rsp_total_ff, rsp_total_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   cpurc_pkg::entry_type wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   cpurc_pkg::entry_type cur;

   logic                 req_fire;
   logic                 exec_go;
   logic                 key_match;
   logic [63:0]          add_sum;
   logic [2:0]           status;
   logic                 out_hit;
   logic [IDX_W-1:0]     out_slot;
   cpurc_pkg::entry_type out_ent;
   cpurc_pkg::entry_type new_ent;

   cpurc_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (cur)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign exec_go   = !rsp_valid_ff || rsp_ready;
   assign key_match = rd_pend_ff && (cur.key == id_ff);
   assign add_sum   = ((op_ff == cpurc_pkg::OP_TICKS) ? cur.ticks : cur.irqs) + amount_ff;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      id_in          = id_ff;
      flag_in        = flag_ff;
      amount_in      = amount_ff;
      rd_idx_in      = rd_idx_ff;
      rd_pend_in     = rd_pend_ff;
      cmp_idx_in     = cmp_idx_ff;
      hit_in         = hit_ff;
      slot_in        = slot_ff;
      entry_total_in = entry_total_ff;
      online_in      = online_ff;
      gen_in         = gen_ff;
      ready_in       = ready_ff;
      failed_in      = failed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_online_in  = rsp_online_ff;
      rsp_ticks_in   = rsp_ticks_ff;
      rsp_irqs_in    = rsp_irqs_ff;
      rsp_gen_in     = rsp_gen_ff;
      rsp_total_in   = rsp_total_ff;
      rd_en          = 1'b0;
      rd_addr        = rd_idx_ff[IDX_W-1:0];
      wr_en          = 1'b0;
      wr_addr        = slot_ff;
      status         = cpurc_pkg::ST_OK;
      out_hit        = hit_ff;
      out_slot       = slot_ff;
      out_ent        = cur;
      new_ent        = cur;
      wr_data        = cur;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in      = req_operation;
               id_in      = req_apic_id;
               flag_in    = req_online_flag;
               amount_in  = req_amount;
               rd_idx_in  = '0;
               rd_pend_in = 1'b0;
               hit_in     = 1'b0;
               state_in   = (req_operation == cpurc_pkg::OP_CLEAR) ? S_EXEC : S_SCAN;
            end
         end
         S_SCAN: begin
            if (key_match) begin
               hit_in     = 1'b1;
               slot_in    = cmp_idx_ff;
               rd_pend_in = 1'b0;
               state_in   = S_EXEC;
            end else if (rd_idx_ff < entry_total_ff) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               cmp_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
            end else begin
               hit_in     = 1'b0;
               rd_pend_in = 1'b0;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               case (op_ff)
                  cpurc_pkg::OP_CLEAR: begin
                     entry_total_in = '0;
                     online_in      = '0;
                     gen_in         = '0;
                     ready_in       = 1'b0;
                     failed_in      = 1'b0;
                     out_hit        = 1'b0;
                  end
                  cpurc_pkg::OP_ADD: begin
                     if (failed_ff || ready_ff) begin
                        status = cpurc_pkg::ST_INVALID;
                     end else if (hit_ff) begin
                        status    = cpurc_pkg::ST_DUPLICATE;
                        failed_in = 1'b1;
                     end else if (entry_total_ff >= CNT_W'(cpurc_pkg::MAX_CPUS)) begin
                        status    = cpurc_pkg::ST_FULL;
                        failed_in = 1'b1;
                     end else begin
                        new_ent.key    = id_ff;
                        new_ent.online = flag_ff;
                        new_ent.ticks  = '0;
                        new_ent.irqs   = '0;
                        wr_en          = 1'b1;
                        wr_addr        = entry_total_ff[IDX_W-1:0];
                        wr_data        = new_ent;
                        entry_total_in = entry_total_ff + CNT_W'(1);
                        online_in      = online_ff + CNT_W'(flag_ff);
                        out_hit        = 1'b1;
                        out_slot       = entry_total_ff[IDX_W-1:0];
                        out_ent        = new_ent;
                     end
                  end
                  cpurc_pkg::OP_COMMIT: begin
                     if (!ready_ff) begin
                        if (failed_ff || entry_total_ff == '0 || online_ff == '0) begin
                           status = cpurc_pkg::ST_INVALID;
                        end else begin
                           gen_in   = 64'd1;
                           ready_in = 1'b1;
                        end
                     end
                  end
                  cpurc_pkg::OP_SET: begin
                     if (!ready_ff) begin
                        status = cpurc_pkg::ST_NOT_READY;
                     end else if (!hit_ff) begin
                        status = cpurc_pkg::ST_NOT_FOUND;
                     end else if (cur.online != flag_ff) begin
                        new_ent.online = flag_ff;
                        wr_en          = 1'b1;
                        wr_data        = new_ent;
                        out_ent        = new_ent;
                        gen_in         = gen_ff + 64'd1;
                        if (flag_ff) begin
                           online_in = online_ff + CNT_W'(1);
                        end else if (online_ff != '0) begin
                           online_in = online_ff - CNT_W'(1);
                        end
                        if (online_in == '0) begin
                           status = cpurc_pkg::ST_INVALID;
                        end
                     end
                  end
                  cpurc_pkg::OP_TICKS, cpurc_pkg::OP_IRQS: begin
                     if (!hit_ff) begin
                        status = cpurc_pkg::ST_NOT_FOUND;
                     end else if (!cur.online || amount_ff == '0) begin
                        status = cpurc_pkg::ST_OFFLINE;
                     end else begin
                        if (op_ff == cpurc_pkg::OP_TICKS) begin
                           new_ent.ticks = add_sum;
                        end else begin
                           new_ent.irqs = add_sum;
                        end
                        wr_en   = 1'b1;
                        wr_data = new_ent;
                        out_ent = new_ent;
                     end
                  end
                  cpurc_pkg::OP_LOOKUP: begin
                     if (!hit_ff) begin
                        status = cpurc_pkg::ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     status = cpurc_pkg::ST_OK;
                  end
               endcase
               rsp_valid_in  = 1'b1;
               rsp_status_in = status;
               rsp_found_in  = out_hit;
               rsp_index_in  = out_hit ? out_slot : '0;
               rsp_online_in = out_hit && out_ent.online;
               rsp_ticks_in  = out_hit ? out_ent.ticks : '0;
               rsp_irqs_in   = out_hit ? out_ent.irqs : '0;
               rsp_gen_in    = gen_in;
               rsp_total_in  = online_in;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rd_pend_ff     <= 1'b0;
         hit_ff         <= 1'b0;
         entry_total_ff <= '0;
         online_ff      <= '0;
         gen_ff         <= '0;
         ready_ff       <= 1'b0;
         failed_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rd_pend_ff     <= rd_pend_in;
         hit_ff         <= hit_in;
         entry_total_ff <= entry_total_in;
         online_ff      <= online_in;
         gen_ff         <= gen_in;
         ready_ff       <= ready_in;
         failed_ff      <= failed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      flag_ff       <= flag_in;
      amount_ff     <= amount_in;
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_online_ff <= rsp_online_in;
      rsp_ticks_ff  <= rsp_ticks_in;
      rsp_irqs_ff   <= rsp_irqs_in;
      rsp_gen_ff    <= rsp_gen_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_logical_index   = 6'(rsp_index_ff);
   assign rsp_entry_online    = rsp_online_ff;
   assign rsp_tick_count      = rsp_ticks_ff;
   assign rsp_interrupt_count = rsp_irqs_ff;
   assign rsp_generation_out  = rsp_gen_ff;
   assign rsp_online_total    = 7'(rsp_total_ff);

   a_online_le_total: assert property (@(posedge clock) disable iff (reset)
      online_ff <= entry_total_ff)
      else $error("online count exceeds entry count");

   a_total_le_max: assert property (@(posedge clock) disable iff (reset)
      entry_total_ff <= CNT_W'(cpurc_pkg::MAX_CPUS))
      else $error("entry count exceeds table size");

   a_ready_nonempty: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (entry_total_ff != '0) && !failed_ff)
      else $error("ready table is empty or failed");

   a_write_only_exec: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_EXEC) && exec_go && !rd_en)
      else $error("entry write outside update cycle");

   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) && exec_go |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("update cycle did not post a result");

endmodule

// ----- verif/cpurc_checker.sv -----
// Reply checker for the processor registry: tracks the table, predicts each reply, compares.
`timescale 1ns / 1ps
module cpurc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_apic_id,
   input  logic        req_online_flag,
   input  logic [63:0] req_amount,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic        rsp_found,
   input  logic [5:0]  rsp_logical_index,
   input  logic        rsp_entry_online,
   input  logic [63:0] rsp_tick_count,
   input  logic [63:0] rsp_interrupt_count,
   input  logic [63:0] rsp_generation_out,
   input  logic [6:0]  rsp_online_total,
   output int unsigned failures,
   output int unsigned pending
);

   typedef struct packed {
      logic [2:0]  status;
      logic        found;
      logic [5:0]  index;
      logic        online;
      logic [63:0] ticks;
      logic [63:0] irqs;
      logic [63:0] gen;
      logic [6:0]  total;
   } reply_type;

   logic [31:0] key_tab  [cpurc_pkg::MAX_CPUS];
   logic        on_tab   [cpurc_pkg::MAX_CPUS];
   logic [63:0] tick_tab [cpurc_pkg::MAX_CPUS];
   logic [63:0] irq_tab  [cpurc_pkg::MAX_CPUS];
   int          entries;
   int          onl;
   logic [63:0] gen;
   logic        ready;
   logic        failed;
   reply_type   reply_q[$];

   function automatic int find_key(logic [31:0] id);
      for (int i = 0; i < entries; i++)
         if (key_tab[i] == id) return i;
      return -1;
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < cpurc_pkg::MAX_CPUS; i++) begin
         key_tab[i]  = '0;
         on_tab[i]   = 1'b0;
         tick_tab[i] = '0;
         irq_tab[i]  = '0;
      end
      entries = 0;
      onl     = 0;
      gen     = '0;
      ready   = 1'b0;
      failed  = 1'b0;
   endfunction

   function automatic reply_type apply_word(logic [2:0] op, logic [31:0] id, logic flag,
                                            logic [63:0] amt);
      reply_type r;
      int        slot;
      r.status = cpurc_pkg::ST_OK;
      case (op)
         cpurc_pkg::OP_CLEAR: wipe_table();
         cpurc_pkg::OP_ADD: begin
            if (failed || ready) begin
               r.status = cpurc_pkg::ST_INVALID;
            end else if (find_key(id) >= 0) begin
               r.status = cpurc_pkg::ST_DUPLICATE;
               failed   = 1'b1;
            end else if (entries >= cpurc_pkg::MAX_CPUS) begin
               r.status = cpurc_pkg::ST_FULL;
               failed   = 1'b1;
            end else begin
               key_tab[entries]  = id;
               on_tab[entries]   = flag;
               tick_tab[entries] = '0;
               irq_tab[entries]  = '0;
               if (flag) onl++;
               entries++;
            end
         end
         cpurc_pkg::OP_COMMIT: begin
            if (!ready) begin
               if (failed || entries == 0 || onl == 0) begin
                  r.status = cpurc_pkg::ST_INVALID;
               end else begin
                  gen   = 64'd1;
                  ready = 1'b1;
               end
            end
         end
         cpurc_pkg::OP_SET: begin
            slot = find_key(id);
            if (!ready) begin
               r.status = cpurc_pkg::ST_NOT_READY;
            end else if (slot < 0) begin
               r.status = cpurc_pkg::ST_NOT_FOUND;
            end else if (on_tab[slot] != flag) begin
               on_tab[slot] = flag;
               if (flag) onl++;
               else if (onl > 0) onl--;
               gen = gen + 64'd1;
               if (onl == 0) r.status = cpurc_pkg::ST_INVALID;
            end
         end
         cpurc_pkg::OP_TICKS, cpurc_pkg::OP_IRQS: begin
            slot = find_key(id);
            if (slot < 0) begin
               r.status = cpurc_pkg::ST_NOT_FOUND;
            end else if (!on_tab[slot] || amt == '0) begin
               r.status = cpurc_pkg::ST_OFFLINE;
            end else if (op == cpurc_pkg::OP_TICKS) begin
               tick_tab[slot] = tick_tab[slot] + amt;
            end else begin
               irq_tab[slot] = irq_tab[slot] + amt;
            end
         end
         cpurc_pkg::OP_LOOKUP: begin
            if (find_key(id) < 0) r.status = cpurc_pkg::ST_NOT_FOUND;
         end
         default: ;
      endcase
      slot = find_key(id);
      r.found = (slot >= 0);
      if (r.found) begin
         r.index  = 6'(slot);
         r.online = on_tab[slot];
         r.ticks  = tick_tab[slot];
         r.irqs   = irq_tab[slot];
      end else begin
         r.index  = '0;
         r.online = 1'b0;
         r.ticks  = '0;
         r.irqs   = '0;
      end
      r.gen   = gen;
      r.total = 7'(onl);
      return r;
   endfunction

   task automatic log_mismatch(string msg);
      $display("%0t checker: %s", $realtime, msg);
      failures++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         log_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         wipe_table();
         reply_q.delete();
      end else begin
         // take the reply before the new word: a reply never belongs to a word of the same edge
         if (rsp_valid && rsp_ready) begin
            if (reply_q.size() == 0) begin
               log_mismatch("reply with no word outstanding");
            end else begin
               want = reply_q.pop_front();
               check_field("status", 64'(rsp_status), 64'(want.status));
               check_field("found", 64'(rsp_found), 64'(want.found));
               check_field("logical_index", 64'(rsp_logical_index), 64'(want.index));
               check_field("entry_online", 64'(rsp_entry_online), 64'(want.online));
               check_field("tick_count", rsp_tick_count, want.ticks);
               check_field("interrupt_count", rsp_interrupt_count, want.irqs);
               check_field("generation_out", rsp_generation_out, want.gen);
               check_field("online_total", 64'(rsp_online_total), 64'(want.total));
            end
         end
         if (req_valid && req_ready)
            reply_q.push_back(apply_word(req_operation, req_apic_id, req_online_flag,
                                         req_amount));
      end
      pending = reply_q.size();
   end

endmodule

// ----- verif/testbench.sv -----
// Top of the processor registry testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;

   localparam logic [2:0] OP_NONE = 3'd7;
   localparam int RANDOM_WORDS = 500;
   localparam int PHASE_WORDS  = 130;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 100;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_operation;
   logic [31:0] req_apic_id;
   logic        req_online_flag;
   logic [63:0] req_amount;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_found;
   logic [5:0]  rsp_logical_index;
   logic        rsp_entry_online;
   logic [63:0] rsp_tick_count;
   logic [63:0] rsp_interrupt_count;
   logic [63:0] rsp_generation_out;
   logic [6:0]  rsp_online_total;

   int unsigned failures;
   int unsigned pending;
   int unsigned sent      = 0;
   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;
   int unsigned quiet     = 0;
   logic [31:0] known_ids[$];

   cpu_registry_counter_table dut (.*);

   cpurc_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_word(logic [2:0] op, logic [31:0] id, logic flag, logic [63:0] amt);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_apic_id     <= id;
      req_online_flag <= flag;
      req_amount      <= amt;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent++;
      case ((sent / PHASE_WORDS) % 4)
         0: begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         1: begin
            idle_pct  = 59;
            stall_pct = 0;
         end
         2: begin
            idle_pct  = 0;
            stall_pct = 59;
         end
         default: begin
            idle_pct  = 21;
            stall_pct = 21;
         end
      endcase
   endtask

   function automatic logic [31:0] pick_id();
      if (known_ids.size() != 0 && $urandom_range(99) < 80)
         return known_ids[$urandom_range(known_ids.size() - 1)];
      return $urandom();
   endfunction

   function automatic logic [63:0] pick_amount();
      case ($urandom_range(9))
         0: return '0;
         1: return {$urandom(), $urandom()};
         // land near the top so counters wrap
         2: return ~64'($urandom_range(255));
         default: return 64'($urandom_range(1, 1000));
      endcase
   endfunction

   initial begin
      int unsigned stop_at;
      int unsigned n;
      int unsigned dup_pct;
      int unsigned r;
      logic [31:0] id;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = cpurc_pkg::OP_CLEAR;
      req_apic_id     = '0;
      req_online_flag = 1'b0;
      req_amount      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, failed build
      send_word(cpurc_pkg::OP_LOOKUP, 32'h0, 1'b0, 64'h0);
      send_word(cpurc_pkg::OP_SET, 32'h1, 1'b1, 64'h0);
      send_word(cpurc_pkg::OP_COMMIT, 32'h0, 1'b0, 64'h0);
      send_word(cpurc_pkg::OP_ADD, 32'h0, 1'b0, 64'h0);
      send_word(cpurc_pkg::OP_COMMIT, 32'h0, 1'b0, 64'h0);
      send_word(cpurc_pkg::OP_ADD, 32'h0, 1'b1, 64'h0);
      send_word(cpurc_pkg::OP_ADD, 32'h5, 1'b1, 64'h0);
      send_word(cpurc_pkg::OP_COMMIT, 32'h0, 1'b0, 64'h0);
      send_word(cpurc_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1'b1, '1);
      // accounting before commit, zero amount, offline entry, wrap
      send_word(cpurc_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b1, 64'h0);
      send_word(cpurc_pkg::OP_ADD, 32'h1234_5678, 1'b0, 64'h0);
      send_word(cpurc_pkg::OP_TICKS, 32'h1234_5678, 1'b0, 64'h5);
      send_word(cpurc_pkg::OP_TICKS, 32'hFFFF_FFFF, 1'b0, 64'h0);
      send_word(cpurc_pkg::OP_IRQS, 32'hDEAD_BEEF, 1'b0, 64'h1);
      send_word(cpurc_pkg::OP_TICKS, 32'hFFFF_FFFF, 1'b0, '1);
      send_word(cpurc_pkg::OP_TICKS, 32'hFFFF_FFFF, 1'b0, 64'h2);
      send_word(cpurc_pkg::OP_IRQS, 32'hFFFF_FFFF, 1'b1, '1);
      // commit, then online changes down to none
      send_word(cpurc_pkg::OP_COMMIT, 32'h0, 1'b0, 64'h0);
      send_word(cpurc_pkg::OP_COMMIT, 32'h0, 1'b0, 64'h0);
      send_word(cpurc_pkg::OP_ADD, 32'hA5A5_A5A5, 1'b1, 64'h0);
      send_word(cpurc_pkg::OP_SET, 32'hFFFF_FFFF, 1'b1, 64'h0);
      send_word(cpurc_pkg::OP_SET, 32'h1234_5678, 1'b1, 64'h0);
      send_word(cpurc_pkg::OP_SET, 32'hFFFF_FFFF, 1'b0, 64'h0);
      send_word(cpurc_pkg::OP_SET, 32'h1234_5678, 1'b0, 64'h0);
      send_word(cpurc_pkg::OP_SET, 32'hDEAD_BEEF, 1'b1, 64'h0);
      send_word(OP_NONE, 32'h5A5A_5A5A, 1'b1, '1);
      send_word(cpurc_pkg::OP_LOOKUP, 32'h1234_5678, 1'b0, 64'h0);

      stop_at = sent + RANDOM_WORDS;
      send_word(cpurc_pkg::OP_CLEAR, $urandom(), 1'($urandom_range(1)), pick_amount());
      while (sent < stop_at) begin
         if ($urandom_range(99) < 85) begin
            send_word(cpurc_pkg::OP_CLEAR, $urandom(), 1'($urandom_range(1)),
                      pick_amount());
            known_ids.delete();
         end
         // build: mostly short tables, now and then a full one and past it
         if ($urandom_range(99) < 8) begin
            n       = cpurc_pkg::MAX_CPUS + $urandom_range(2);
            dup_pct = 0;
         end else begin
            n       = $urandom_range(1, 8);
            dup_pct = 8;
         end
         repeat (n) begin
            if (known_ids.size() != 0 && $urandom_range(99) < dup_pct) begin
               id = known_ids[$urandom_range(known_ids.size() - 1)];
            end else begin
               id = $urandom();
               known_ids.push_back(id);
            end
            send_word(cpurc_pkg::OP_ADD, id, $urandom_range(99) < 70, pick_amount());
         end
         if ($urandom_range(99) < 90)
            send_word(cpurc_pkg::OP_COMMIT, pick_id(), 1'($urandom_range(1)), pick_amount());
         if ($urandom_range(99) < 10)
            send_word(cpurc_pkg::OP_COMMIT, pick_id(), 1'($urandom_range(1)), pick_amount());
         repeat ($urandom_range(8, 24)) begin
            r = $urandom_range(99);
            if (r < 30)
               send_word(cpurc_pkg::OP_SET, pick_id(), 1'($urandom_range(1)),
                         pick_amount());
            else if (r < 55)
               send_word(cpurc_pkg::OP_TICKS, pick_id(), 1'($urandom_range(1)),
                         pick_amount());
            else if (r < 75)
               send_word(cpurc_pkg::OP_IRQS, pick_id(), 1'($urandom_range(1)),
                         pick_amount());
            else if (r < 88)
               send_word(cpurc_pkg::OP_LOOKUP, pick_id(), 1'($urandom_range(1)),
                         pick_amount());
            else if (r < 93)
               send_word(cpurc_pkg::OP_ADD, pick_id(), 1'($urandom_range(1)),
                         pick_amount());
            else if (r < 96)
               send_word(cpurc_pkg::OP_COMMIT, pick_id(), 1'($urandom_range(1)),
                         pick_amount());
            else
               send_word(OP_NONE, pick_id(), 1'($urandom_range(1)), pick_amount());
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
